FILE: rtl/core/bisection_square_root_defines.svh
// assertion macros shared by the checker
`ifndef BISECTION_SQUARE_ROOT_DEFINES_SVH
`define BISECTION_SQUARE_ROOT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define BSR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define BSR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/bsr_pkg.sv
`default_nettype none

package bsr_pkg;

    // number formats
    localparam int FRAC_BITS = 24;
    localparam int DATA_W    = 32;
    localparam int SUM_W     = DATA_W + 1;
    localparam int CFG_W     = 31;
    localparam int ITER_W    = 6;
    localparam int STATUS_W  = 2;
    localparam int MAX_ITER  = 32;
    localparam int EPS_MIN   = 2;

    // serial squarer: one radix-16 digit of the operand per cycle
    localparam int DIGIT_W   = 4;
    localparam int SQ_STEPS  = DATA_W / DIGIT_W;
    localparam int SQ_CNT_W  = $clog2(SQ_STEPS + 1);
    localparam int PROD_W    = 2 * DATA_W;
    localparam int PP_W      = DATA_W + DIGIT_W;

    // reset values of the registers
    localparam logic [CFG_W-1:0] TARGET_RESET  = CFG_W'(50331648);
    localparam logic [CFG_W-1:0] EPSILON_RESET = CFG_W'(168);

    typedef logic [STATUS_W-1:0] status_t;

    localparam status_t ST_APPROX  = 2'd0;
    localparam status_t ST_EXACT   = 2'd1;
    localparam status_t ST_INVALID = 2'd2;
    localparam status_t ST_NARROW  = 2'd3;

    typedef logic [0:0] reg_idx_t;

    localparam reg_idx_t REG_TARGET  = 1'b0;
    localparam reg_idx_t REG_EPSILON = 1'b1;

endpackage

`default_nettype wire

FILE: rtl/core/bisection_square_root.sv
`default_nettype none

// Bisection square root: each item [left_end, right_end] (signed Q8.24) is
// bisected toward the root of x*x - target, giving one result per iteration
// (floored midpoint, iteration number, approximate or exact status) and a
// final result flagged by last; endpoints whose f values share a sign or hit
// zero give one endpoints-invalid result, an interval already narrower than
// epsilon one interval-too-narrow result. Only the sign of f is used, from an
// exact 64-bit square compared with target << 24. The squares come from one
// serial multiplier that takes a 4-bit digit of the operand per cycle; an item
// runs two endpoint squares, then a square and a result hand-off per iteration
// (1 to 32 iterations), each hand-off waiting while the output is stalled, and
// then returns to idle; an item with a special status gives its one result
// right after the endpoint tests. A new item is taken once the final result of
// the previous one sits in the output register. Epsilon below 2 acts as 2.
module bisection_square_root
    import bsr_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     wr_en,
    input  wire reg_idx_t                 wr_index,
    input  wire logic [CFG_W-1:0]         wr_data,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic signed [DATA_W-1:0] left_end,
    input  wire logic signed [DATA_W-1:0] right_end,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic signed [DATA_W-1:0]      approx,
    output logic [ITER_W-1:0]             iteration,
    output status_t                       status,
    output logic                          last
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SQA  = 3'd1;
    localparam logic [2:0] S_SQB  = 3'd2;
    localparam logic [2:0] S_SQC  = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    // control registers
    logic [2:0]          state_reg, state_next;
    logic [CFG_W-1:0]    target_reg, target_next;
    logic [CFG_W-1:0]    epsilon_reg, epsilon_next;
    logic                out_valid_reg, out_valid_next;
    logic [SQ_CNT_W-1:0] sq_cnt_reg, sq_cnt_next;

    // datapath registers
    logic signed [DATA_W-1:0] a_reg, a_next;
    logic signed [DATA_W-1:0] b_reg, b_next;
    logic signed [DATA_W-1:0] c_reg, c_next;
    logic                     sa_neg_reg, sa_neg_next;
    logic                     sa_zero_reg, sa_zero_next;
    logic [ITER_W-1:0]        iter_reg, iter_next;
    status_t                  res_status_reg, res_status_next;
    logic                     res_done_reg, res_done_next;
    logic [DATA_W-1:0]        sq_mag_reg, sq_mag_next;
    logic [DATA_W-1:0]        sq_mplr_reg, sq_mplr_next;
    logic [PROD_W-1:0]        sq_acc_reg, sq_acc_next;
    logic signed [DATA_W-1:0] approx_reg, approx_next;
    logic [ITER_W-1:0]        iteration_reg, iteration_next;
    status_t                  status_reg, status_next;
    logic                     last_reg, last_next;

    // combinational helpers
    logic signed [SUM_W-1:0]  diff;
    logic signed [SUM_W-1:0]  sum;
    logic signed [DATA_W-1:0] mid;
    logic [CFG_W-1:0]         eps_eff;
    logic                     narrow;
    logic                     sq_done;
    logic [PROD_W-1:0]        tgt_scaled;
    logic                     sq_lt;
    logic                     sq_eq;
    logic [DIGIT_W-1:0]       digit;
    logic [PP_W-1:0]          pp;
    logic [PROD_W-1:0]        acc_step;
    logic                     out_free;
    logic                     emit_last;
    logic                     sq_start;
    logic signed [DATA_W-1:0] sq_opnd;
    logic [DATA_W-1:0]        sq_opnd_mag;

    // interval width, midpoint and stop test
    assign diff     = SUM_W'(b_reg) - SUM_W'(a_reg);
    assign sum      = SUM_W'(a_reg) + SUM_W'(b_reg);
    assign mid      = sum[SUM_W-1:1];
    assign eps_eff  = (epsilon_reg < CFG_W'(EPS_MIN)) ? CFG_W'(EPS_MIN) : epsilon_reg;
    assign narrow   = diff < $signed(SUM_W'(eps_eff));

    // serial squarer step and sign of f
    assign sq_done    = (sq_cnt_reg == SQ_CNT_W'(SQ_STEPS));
    assign tgt_scaled = PROD_W'(target_reg) << FRAC_BITS;
    assign sq_lt      = sq_acc_reg < tgt_scaled;
    assign sq_eq      = sq_acc_reg == tgt_scaled;
    assign digit      = sq_mplr_reg[DATA_W-1 -: DIGIT_W];
    assign pp         = PP_W'(sq_mag_reg) * PP_W'(digit);
    assign acc_step   = (sq_acc_reg << DIGIT_W) + PROD_W'(pp);
    assign sq_opnd_mag = sq_opnd[DATA_W-1] ? (~sq_opnd) + 1'b1 : sq_opnd;

    // output hand-off
    assign out_free  = !out_valid_reg || out_ready;
    assign emit_last = res_done_reg || narrow || (iter_reg == ITER_W'(MAX_ITER));

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign approx    = approx_reg;
    assign iteration = iteration_reg;
    assign status    = status_reg;
    assign last      = last_reg;

    // next-state logic
    always_comb
    begin
        state_next      = state_reg;
        target_next     = target_reg;
        epsilon_next    = epsilon_reg;
        out_valid_next  = out_valid_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        c_next          = c_reg;
        sa_neg_next     = sa_neg_reg;
        sa_zero_next    = sa_zero_reg;
        iter_next       = iter_reg;
        res_status_next = res_status_reg;
        res_done_next   = res_done_reg;
        approx_next     = approx_reg;
        iteration_next  = iteration_reg;
        status_next     = status_reg;
        last_next       = last_reg;
        sq_start        = 1'b0;
        sq_opnd         = mid;

        // configuration writes
        if (wr_en)
        begin
            unique case (wr_index)
                REG_TARGET:  target_next  = wr_data;
                REG_EPSILON: epsilon_next = wr_data;
                default:     target_next  = target_reg;
            endcase
        end

        // result taken downstream
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    a_next     = left_end;
                    b_next     = right_end;
                    sq_start   = 1'b1;
                    sq_opnd    = left_end;
                    state_next = S_SQA;
                end
            end
            S_SQA:
            begin
                if (sq_done)
                begin
                    sa_neg_next  = sq_lt;
                    sa_zero_next = sq_eq;
                    sq_start     = 1'b1;
                    sq_opnd      = b_reg;
                    state_next   = S_SQB;
                end
            end
            S_SQB:
            begin
                if (sq_done)
                begin
                    priority if (sa_zero_reg || sq_eq || (sa_neg_reg == sq_lt))
                    begin
                        c_next          = '0;
                        iter_next       = '0;
                        res_status_next = ST_INVALID;
                        res_done_next   = 1'b1;
                        state_next      = S_EMIT;
                    end
                    else if (narrow)
                    begin
                        c_next          = '0;
                        iter_next       = '0;
                        res_status_next = ST_NARROW;
                        res_done_next   = 1'b1;
                        state_next      = S_EMIT;
                    end
                    else
                    begin
                        c_next     = mid;
                        iter_next  = ITER_W'(1);
                        sq_start   = 1'b1;
                        state_next = S_SQC;
                    end
                end
            end
            S_SQC:
            begin
                if (sq_done)
                begin
                    if (sq_eq)
                    begin
                        res_status_next = ST_EXACT;
                        res_done_next   = 1'b1;
                    end
                    else
                    begin
                        res_status_next = ST_APPROX;
                        res_done_next   = 1'b0;
                        // keep the half whose ends still straddle the root
                        if (sq_lt != sa_neg_reg)
                        begin
                            b_next = c_reg;
                        end
                        else
                        begin
                            a_next = c_reg;
                        end
                    end
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    approx_next    = c_reg;
                    iteration_next = iter_reg;
                    status_next    = res_status_reg;
                    last_next      = emit_last;
                    if (emit_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        c_next     = mid;
                        iter_next  = iter_reg + 1'b1;
                        sq_start   = 1'b1;
                        state_next = S_SQC;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // squarer: load the magnitude, then one digit per cycle, msb first
    always_comb
    begin
        sq_mag_next  = sq_mag_reg;
        sq_mplr_next = sq_mplr_reg;
        sq_acc_next  = sq_acc_reg;
        sq_cnt_next  = sq_cnt_reg;
        priority if (sq_start)
        begin
            sq_mag_next  = sq_opnd_mag;
            sq_mplr_next = sq_opnd_mag;
            sq_acc_next  = '0;
            sq_cnt_next  = '0;
        end
        else if (!sq_done)
        begin
            sq_acc_next  = acc_step;
            sq_mplr_next = sq_mplr_reg << DIGIT_W;
            sq_cnt_next  = sq_cnt_reg + 1'b1;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            target_reg    <= TARGET_RESET;
            epsilon_reg   <= EPSILON_RESET;
            out_valid_reg <= 1'b0;
            sq_cnt_reg    <= SQ_CNT_W'(SQ_STEPS);
        end
        else
        begin
            state_reg     <= state_next;
            target_reg    <= target_next;
            epsilon_reg   <= epsilon_next;
            out_valid_reg <= out_valid_next;
            sq_cnt_reg    <= sq_cnt_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        a_reg          <= a_next;
        b_reg          <= b_next;
        c_reg          <= c_next;
        sa_neg_reg     <= sa_neg_next;
        sa_zero_reg    <= sa_zero_next;
        iter_reg       <= iter_next;
        res_status_reg <= res_status_next;
        res_done_reg   <= res_done_next;
        sq_mag_reg     <= sq_mag_next;
        sq_mplr_reg    <= sq_mplr_next;
        sq_acc_reg     <= sq_acc_next;
        approx_reg     <= approx_next;
        iteration_reg  <= iteration_next;
        status_reg     <= status_next;
        last_reg       <= last_next;
    end

endmodule

`default_nettype wire

FILE: rtl/core/bsr_checker.sv
`default_nettype none

`include "bisection_square_root_defines.svh"

module bsr_checker
    import bsr_pkg::*;
(
    input wire logic                     clk,
    input wire logic                     rst_n,
    input wire logic                     in_valid,
    input wire logic                     in_ready,
    input wire logic                     out_valid,
    input wire logic                     out_ready,
    input wire logic signed [DATA_W-1:0] approx,
    input wire logic [ITER_W-1:0]        iteration,
    input wire status_t                  status,
    input wire logic                     last
);

    // one item at a time: input closes right after an item is taken
    `BSR_ASSERT_NEXT(a_in_single, clk, rst_n, in_valid && in_ready, !in_ready,
        "input stayed open after an item was taken")

    // a stalled item holds its payload
    `BSR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(approx) && $stable(iteration) && $stable(status)
        && $stable(last), "output item changed while stalled")

    // special outcomes are single, empty results
    `BSR_ASSERT_NOW(a_special_form, clk, rst_n,
        out_valid && (status == ST_INVALID || status == ST_NARROW),
        last && iteration == '0 && approx == '0, "malformed special result")

    // an exact root ends the item
    `BSR_ASSERT_NOW(a_exact_last, clk, rst_n, out_valid && status == ST_EXACT,
        last && iteration != '0, "exact root not flagged last")

    // iteration results are numbered within range
    `BSR_ASSERT_NOW(a_iter_range, clk, rst_n, out_valid && status == ST_APPROX,
        iteration != '0 && iteration <= ITER_W'(MAX_ITER), "iteration out of range")

endmodule

bind bisection_square_root bsr_checker u_bsr_checker (.*);

`default_nettype wire
